// ===== src/ecpc_pkg.sv =====
// Shared types, constants and palette tables for the escape count colorizer.
// The palette tables are built at elaboration by constant functions.
// No dependencies.
`default_nettype none
package ecpc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int IDX_WIDTH = 8;
  localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(256);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_PALETTE = 2'd0,
    CFG_LIMIT   = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    PAL_CLASSIC   = 3'd0,
    PAL_FIRE      = 3'd1,
    PAL_OCEAN     = 3'd2,
    PAL_RAINBOW   = 3'd3,
    PAL_GRAYSCALE = 3'd4,
    PAL_ELECTRIC  = 3'd5
  } palette_t;

  // One item as it travels down the divider pipeline.
  typedef struct packed {
    logic                   valid;
    logic                   black;
    logic [2:0]             sel;
    logic [COUNT_WIDTH-1:0] lim;
    logic [COUNT_WIDTH-1:0] rem;
    logic [IDX_WIDTH-1:0]   quo;
  } stage_t;

  // Color entries hold red in the low byte, then green, then blue.
  typedef logic [23:0] pal_t [256];

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_Q30      = (PI_Q60 + (64'd1 << 29)) >> 30;
  localparam logic [63:0] HALF_PI_Q30 = (PI_Q60 + (64'd1 << 30)) >> 31;
  localparam logic [63:0] TWO_PI_Q30  = 64'd2 * PI_Q30;

  // Fixed point level floor(255*(1+sin(a))/2) for an unsigned Q30 angle.
  function automatic logic [7:0] wave_level(input logic [63:0] ang);
    logic        neg;
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] v;
    neg = 1'b0;
    a = ang % TWO_PI_Q30;
    if (a >= PI_Q30) begin
      a = a - PI_Q30;
      neg = 1'b1;
    end
    if (a > HALF_PI_Q30) a = PI_Q30 - a;
    x2 = (a * a) >> 30;
    t = Q30_ONE;
    for (int k = 8; k >= 1; k--) begin
      d = ((x2 * t) >> 30) / 64'((2 * k) * (2 * k + 1));
      t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    end
    s = (a * t) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    v = neg ? (Q30_ONE - s) : (Q30_ONE + s);
    v = (64'd255 * v) >> 31;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] wave_entry(input logic [63:0] phase100,
                                            input logic [63:0] rate100,
                                            input logic [63:0] i,
                                            input logic        use_cos);
    logic [63:0] ang;
    ang = ((phase100 * 64'd255 + i * rate100) << 30) / 64'd25500;
    if (use_cos) ang = ang + HALF_PI_Q30;
    return wave_level(ang);
  endfunction

  // Builds the 256 entries of one palette.
  function automatic pal_t build_pal(input int unsigned p);
    pal_t        tab;
    logic [63:0] i;
    logic [63:0] sec;
    logic [63:0] f;
    logic [7:0]  up;
    logic [7:0]  dn;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    for (int n = 0; n < 256; n++) begin
      i = 64'(n);
      sec = (64'd2 * i) / 64'd85;
      f = (64'd2 * i) % 64'd85;
      up = 8'(64'd3 * f);
      dn = 8'(64'd255 - 64'd3 * f);
      r = 8'd0;
      g = 8'd0;
      b = 8'd0;
      case (p)
        0: begin
          r = wave_entry(64'd300, 64'd628, i, 1'b1);
          g = wave_entry(64'd200, 64'd628, i, 1'b1);
          b = wave_entry(64'd100, 64'd628, i, 1'b1);
        end
        1: begin
          r = (2 * n > 255) ? 8'd255 : 8'(2 * n);
          // Green ramps from 153 and saturates at full scale.
          g = (2 * n < 153) ? 8'd0 : (2 * n - 153 > 255) ? 8'd255 : 8'(2 * n - 153);
          b = (n >= 179) ? 8'(3 * n - 536) : 8'd0;
        end
        2: begin
          r = 8'((3 * n) / 10);
          g = 8'((765 + 4 * n) / 10);
          b = 8'((255 + n) / 2);
        end
        3: begin
          case (sec % 64'd6)
            64'd0: begin r = 8'd255; g = up; end
            64'd1: begin r = dn; g = 8'd255; end
            64'd2: begin g = 8'd255; b = up; end
            64'd3: begin g = dn; b = 8'd255; end
            64'd4: begin r = up; b = 8'd255; end
            default: begin r = 8'd255; b = dn; end
          endcase
        end
        4: begin
          r = 8'(n);
          g = 8'(n);
          b = 8'(n);
        end
        default: begin
          r = wave_entry(64'd0, 64'd1256, i, 1'b0);
          g = wave_entry(64'd209, 64'd1884, i, 1'b0);
          b = wave_entry(64'd418, 64'd2512, i, 1'b0);
        end
      endcase
      tab[n] = {b, g, r};
    end
    return tab;
  endfunction

  localparam pal_t PAL_CLASSIC_ROM   = build_pal(0);
  localparam pal_t PAL_FIRE_ROM      = build_pal(1);
  localparam pal_t PAL_OCEAN_ROM     = build_pal(2);
  localparam pal_t PAL_RAINBOW_ROM   = build_pal(3);
  localparam pal_t PAL_GRAYSCALE_ROM = build_pal(4);
  localparam pal_t PAL_ELECTRIC_ROM  = build_pal(5);

endpackage
`default_nettype wire

// ===== src/ecpc_div_step.sv =====
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on ecpc_pkg.
`default_nettype none
module ecpc_div_step (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire ecpc_pkg::stage_t st_in,
  output ecpc_pkg::stage_t     st_out
);
  import ecpc_pkg::*;

  logic [COUNT_WIDTH:0] twice;
  logic                 fits;
  stage_t               st_next;

  // Shift the remainder and subtract the limit where it fits.
  always_comb begin
    twice = {st_in.rem, 1'b0};
    fits = twice >= {1'b0, st_in.lim};
    st_next = st_in;
    st_next.quo = {st_in.quo[IDX_WIDTH-2:0], fits};
    if (fits) begin
      st_next.rem = COUNT_WIDTH'(twice - {1'b0, st_in.lim});
    end else begin
      st_next.rem = twice[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_out.valid <= 1'b0;
    end else if (en) begin
      st_out.valid <= st_next.valid;
    end
    if (en) begin
      st_out.black <= st_next.black;
      st_out.sel <= st_next.sel;
      st_out.lim <= st_next.lim;
      st_out.rem <= st_next.rem;
      st_out.quo <= st_next.quo;
    end
  end

endmodule
`default_nettype wire

// ===== src/escape_count_palette_colorizer.sv =====
// Top level of the escape count colorizer: input register, divider pipeline,
// palette lookup and output register. Depends on ecpc_pkg and ecpc_div_step.
//
//  channel  dir  handshake           payload
//  s_axis   in   s_tvalid/s_tready   s_tdata[15:0] escape_count
//  m_axis   out  m_tvalid/m_tready   m_tdata[23:0] red, green, blue
//  cfg      in   cfg_we              cfg_index, cfg_data
//
// One pixel per clock while the output is not held. The stages are one input
// stage, eight divider stages (one quotient bit each) and the output register
// after the palette lookup. Reset clears the valid bits and the registers
// (palette 0, limit 256). When the output is held the whole pipeline holds.
`default_nettype none
module escape_count_palette_colorizer (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [15:0]                            s_tdata,  // escape_count
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [23:0]                                 m_tdata,  // red, green, blue
  input  wire logic                                   cfg_we,
  input  wire logic [ecpc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [ecpc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
  import ecpc_pkg::*;

  localparam int DIV_STEPS = IDX_WIDTH;

  logic [2:0]             palette_select;
  logic [COUNT_WIDTH-1:0] max_iteration_limit;
  logic                   advance;
  stage_t                 st [DIV_STEPS+1];
  stage_t                 st0_next;
  logic [COUNT_WIDTH:0]   count_plus;
  logic [23:0]            color;
  logic [IDX_WIDTH-1:0]   idx;

  assign advance = m_tready || !m_tvalid;
  assign s_tready = advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select <= PAL_CLASSIC;
      max_iteration_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_PALETTE: palette_select <= cfg_data[2:0];
        CFG_LIMIT:   max_iteration_limit <= cfg_data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input stage: black test and the starting remainder of (count+1)*256/limit.
  always_comb begin
    count_plus = {1'b0, s_tdata[COUNT_WIDTH-1:0]} + 1'b1;
    st0_next.valid = s_tvalid;
    st0_next.black = (s_tdata[COUNT_WIDTH-1:0] >= max_iteration_limit) ||
                     (palette_select > PAL_ELECTRIC);
    st0_next.sel = palette_select;
    st0_next.lim = max_iteration_limit;
    st0_next.quo = '0;
    // A count one below the limit gives a quotient of 256, which wraps to 0.
    if (count_plus == {1'b0, max_iteration_limit}) begin
      st0_next.rem = '0;
    end else begin
      st0_next.rem = count_plus[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (advance) begin
      st[0].valid <= st0_next.valid;
    end
    if (advance) begin
      st[0].black <= st0_next.black;
      st[0].sel <= st0_next.sel;
      st[0].lim <= st0_next.lim;
      st[0].rem <= st0_next.rem;
      st[0].quo <= st0_next.quo;
    end
  end

  // Divider pipeline.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    ecpc_div_step u_step (
      .clk    (clk),
      .rst    (rst),
      .en     (advance),
      .st_in  (st[g]),
      .st_out (st[g+1])
    );
  end

  // Palette lookup.
  always_comb begin
    idx = st[DIV_STEPS].quo;
    case (palette_t'(st[DIV_STEPS].sel))
      PAL_CLASSIC:   color = PAL_CLASSIC_ROM[idx];
      PAL_FIRE:      color = PAL_FIRE_ROM[idx];
      PAL_OCEAN:     color = PAL_OCEAN_ROM[idx];
      PAL_RAINBOW:   color = PAL_RAINBOW_ROM[idx];
      PAL_GRAYSCALE: color = PAL_GRAYSCALE_ROM[idx];
      PAL_ELECTRIC:  color = PAL_ELECTRIC_ROM[idx];
      default:       color = '0;
    endcase
    if (st[DIV_STEPS].black) color = '0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= st[DIV_STEPS].valid;
    end
    if (advance) begin
      m_tdata <= color;
    end
  end

`ifndef NO_ASSERTIONS
  // After reset no result is offered.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A held result keeps its color.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("held result changed");

  // The divider remainder stays below the limit for colored pixels.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (st[DIV_STEPS].valid && !st[DIV_STEPS].black) |->
      (st[DIV_STEPS].rem < st[DIV_STEPS].lim))
    else $error("divider remainder out of range");

  // Black pixels leave the lookup as black.
  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && st[DIV_STEPS].valid && st[DIV_STEPS].black) |=> (m_tdata == 24'd0))
    else $error("black pixel colored");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for escape_count_palette_colorizer: streams escape counts,
// predicts each RGB color from independently built palette tables and checks every
// output transfer. Depends on ecpc_pkg and the colorizer RTL.
`default_nettype none

// Holds the expected colors in arrival order and compares the output transfers.
class colour_scoreboard;
  logic [23:0] pending_colours[$];
  int          mismatches;
  int          checked;

  function void note_pixel(logic [23:0] colour);
    pending_colours.push_back(colour);
  endfunction

  function void check_pixel(logic [23:0] got);
    logic [23:0] want;
    checked++;
    if (pending_colours.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output transfer rgb=%h", got);
    end else begin
      want = pending_colours.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("color mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want[7:0], want[15:8], want[23:16], got[7:0], got[15:8], got[23:16]);
      end
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ecpc_pkg::*;

  localparam int                          CYCLE_LIMIT = 400000;
  localparam int                          DRAIN_CYCLES = 14;
  localparam logic [CFG_INDEX_WIDTH-1:0]  CFG_SPARE = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0]  CFG_SPARE_HI = 2'd3;
  localparam logic [63:0]                 ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0]                 PI_FRAC60 = 64'h3243F6A8885A308D;
  localparam logic [63:0]                 PI_FIX = (PI_FRAC60 + (64'd1 << 29)) >> 30;
  localparam logic [63:0]                 HALF_PI_FIX = (PI_FRAC60 + (64'd1 << 30)) >> 31;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [15:0]                 s_tdata = '0;  // escape_count
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [23:0]                 m_tdata;       // red, green, blue
  logic                        cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]  cfg_index = CFG_PALETTE;
  logic [CFG_DATA_WIDTH-1:0]   cfg_data = '0;

  colour_scoreboard board = new();
  logic [23:0]      colour_rom[6][256];
  logic [2:0]       model_palette = PAL_CLASSIC;
  logic [15:0]      model_limit = 16'd256;
  int               tx_idle = 0;
  int               rx_idle = 0;
  int               cycles = 0;
  int               sent = 0;

  escape_count_palette_colorizer dut (.*);

  always #4 clk = ~clk;

  // Level floor(255*(1+sin(a))/2) for an unsigned Q30 angle.
  function automatic logic [7:0] sine_byte(logic [63:0] angle);
    logic        negative;
    logic [63:0] a, sq, term, part, s, level;
    negative = 1'b0;
    a = angle % (64'd2 * PI_FIX);
    if (a >= PI_FIX) begin
      a = a - PI_FIX;
      negative = 1'b1;
    end
    if (a > HALF_PI_FIX) a = PI_FIX - a;
    sq = (a * a) >> 30;
    term = ONE_Q30;
    for (int k = 8; k >= 1; k--) begin
      part = ((sq * term) >> 30) / 64'((2 * k) * (2 * k + 1));
      term = (part >= ONE_Q30) ? 64'd0 : ONE_Q30 - part;
    end
    s = (a * term) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    level = negative ? ONE_Q30 - s : ONE_Q30 + s;
    level = (64'd255 * level) >> 31;
    return (level > 64'd255) ? 8'd255 : level[7:0];
  endfunction

  function automatic logic [7:0] wave_byte(int phase, int rate, int n, bit cosine);
    logic [63:0] angle;
    angle = ((64'(phase) * 64'd255 + 64'(n) * 64'(rate)) << 30) / 64'd25500;
    if (cosine) angle = angle + HALF_PI_FIX;
    return sine_byte(angle);
  endfunction

  // Expected color of one pixel under the current register settings.
  function automatic logic [23:0] pixel_colour(logic [15:0] count);
    logic [31:0] index;
    if (count >= model_limit || model_palette > PAL_ELECTRIC) return 24'd0;
    index = ((32'(count) + 32'd1) * 32'd256) / 32'(model_limit);
    return colour_rom[model_palette][index[7:0]];
  endfunction

  // Palette tables, red in the low byte.
  initial begin
    int sec, f;
    logic [7:0] r, g, b, up, dn;
    for (int n = 0; n < 256; n++) begin
      colour_rom[PAL_CLASSIC][n] = {wave_byte(100, 628, n, 1), wave_byte(200, 628, n, 1),
                                    wave_byte(300, 628, n, 1)};
      r = (2 * n > 255) ? 8'd255 : 8'(2 * n);
      g = (2 * n < 153) ? 8'd0 : (2 * n - 153 > 255) ? 8'd255 : 8'(2 * n - 153);
      b = (n >= 179) ? 8'(3 * n - 536) : 8'd0;
      colour_rom[PAL_FIRE][n] = {b, g, r};
      colour_rom[PAL_OCEAN][n] = {8'((255 + n) / 2), 8'((765 + 4 * n) / 10), 8'((3 * n) / 10)};
      sec = (2 * n) / 85;
      f = (2 * n) % 85;
      up = 8'(3 * f);
      dn = 8'(255 - 3 * f);
      r = 0; g = 0; b = 0;
      case (sec % 6)
        0: begin r = 255; g = up; end
        1: begin r = dn; g = 255; end
        2: begin g = 255; b = up; end
        3: begin g = dn; b = 255; end
        4: begin r = up; b = 255; end
        default: begin r = 255; b = dn; end
      endcase
      colour_rom[PAL_RAINBOW][n] = {b, g, r};
      colour_rom[PAL_GRAYSCALE][n] = {8'(n), 8'(n), 8'(n)};
      colour_rom[PAL_ELECTRIC][n] = {wave_byte(418, 2512, n, 0), wave_byte(209, 1884, n, 0),
                                     wave_byte(0, 1256, n, 0)};
    end
  end

  // Output side: check each transfer and stall at random.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_pixel(m_tdata);
      m_tready <= ($urandom_range(99) >= rx_idle);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("escape_count_palette_colorizer verification failed");
      $finish;
    end
  end

  // Sends one escape count; the expectation is noted at the transfer.
  task automatic send_pixel(logic [15:0] count);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= count;
    do @(posedge clk); while (!s_tready);
    board.note_pixel(pixel_colour(count));
    sent++;
  endtask

  // Stops the stream and waits until the pipeline is empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending_colours.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the write port then goes idle before the task returns.
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_PALETTE) model_palette = value[2:0];
    else if (index == CFG_LIMIT) model_limit = value;
    @(posedge clk);
  endtask

  task automatic set_colouring(logic [2:0] palette, logic [15:0] limit);
    drain();
    write_reg(CFG_PALETTE, 16'(palette));
    write_reg(CFG_LIMIT, limit);
  endtask

  initial begin
    logic [15:0] limits[9] = '{16'd256, 16'd65535, 16'd1, 16'd0, 16'd17, 16'd1000,
                               16'd255, 16'd3, 16'd40000};
    logic [15:0] count;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, edges of the count, black and wrap cases.
    tx_idle = 20;
    rx_idle = 20;
    foreach (limits[k]) if (k < 1) begin
      send_pixel(16'd0);
      send_pixel(16'd1);
      send_pixel(16'd128);
      send_pixel(16'd255);
      send_pixel(16'd256);
      send_pixel(16'hFFFF);
    end
    set_colouring(PAL_FIRE, 16'd0);
    send_pixel(16'd0);
    send_pixel(16'hFFFF);
    set_colouring(PAL_OCEAN, 16'hFFFF);
    send_pixel(16'hFFFE);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);
    set_colouring(PAL_RAINBOW, 16'd1);
    send_pixel(16'd0);
    send_pixel(16'h5555);
    set_colouring(PAL_GRAYSCALE, 16'd512);
    send_pixel(16'd511);
    send_pixel(16'd300);
    set_colouring(PAL_ELECTRIC, 16'd300);
    send_pixel(16'hAAAA);
    send_pixel(16'd150);
    set_colouring(3'd6, 16'd300);
    send_pixel(16'd10);
    set_colouring(3'd7, 16'd300);
    send_pixel(16'd20);
    // Writes to unused register indexes must change nothing.
    drain();
    write_reg(CFG_SPARE, 16'h0003);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    send_pixel(16'd20);

    // Random phases: each sets the palette, the limit and the idle pattern.
    for (int p = 0; p < 9; p++) begin
      set_colouring(3'(p), limits[p]);
      tx_idle = (p < 3) ? 33 : (p < 6) ? 69 : 0;
      rx_idle = (p < 3) ? 69 : (p < 6) ? 33 : 0;
      for (int n = 0; n < 92; n++) begin
        if (p == 4 && n == 40) drain();
        if ($urandom_range(9) < 7 && limits[p] != 0) count = 16'($urandom_range(limits[p] - 1));
        else count = 16'($urandom);
        send_pixel(count);
      end
    end

    drain();
    $display("covered %0d pixels over all six palettes, the unused selects and limits 0 to 65535",
             sent);
    $display("%0d output transfers checked, %0d mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_colours.size() == 0)
      $display("escape_count_palette_colorizer verification clean");
    else
      $display("escape_count_palette_colorizer verification failed");
    $finish;
  end
endmodule

`default_nettype wire
